// ===== rtl/sds_pkg.sv =====
// package for sample_dispersion_stats: widths, limits, status codes, states
// no dependencies
package sds_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned SampleW  = 24;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = AddrW + 1;
  localparam int unsigned SumW     = 34;
  localparam int unsigned AccW     = 64;
  localparam int unsigned VarW     = 48;
  localparam int unsigned RootW    = VarW / 2;
  localparam int unsigned DiffW    = SampleW + 2;
  localparam int unsigned StepW    = 7;

  typedef logic signed [SampleW-1:0] sample_t;

  localparam sample_t SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleW-1){1'b0}}};

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusEmpty    = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  typedef enum logic [7:0] {
    StLoad  = 8'b00000001,
    StPrep  = 8'b00000010,
    StMean  = 8'b00000100,
    StRound = 8'b00001000,
    StPass  = 8'b00010000,
    StVar   = 8'b00100000,
    StSqrt  = 8'b01000000,
    StOut   = 8'b10000000
  } state_e;
endpackage

// ===== rtl/sample_dispersion_stats.sv =====
// sample_dispersion_stats: set statistics over a 1024 x 24 sample memory; uses sds_pkg
// throughput: one sample transfer per cycle while loading
// after a last transfer ready_o stays low until the result is registered (longer while
// an earlier result waits): rounded 64-step mean divide, pipelined memory pass, 64-step
// variance divide, square root; an empty set goes straight to the output
// reset: asynchronous active low, clears count, sum, min, max, overflow; memory kept
module sample_dispersion_stats (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  sds_pkg::sample_t            sample_i,
  input  logic                        has_sample_i,
  input  logic                        last_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [sds_pkg::CountW-1:0]  sample_count_o,
  output sds_pkg::sample_t            mean_value_o,
  output sds_pkg::sample_t            minimum_o,
  output sds_pkg::sample_t            maximum_o,
  output logic [sds_pkg::SampleW-1:0] swing_o,
  output logic [sds_pkg::VarW-1:0]    variance_o,
  output logic [sds_pkg::RootW-1:0]   std_deviation_o,
  output logic [1:0]                  status_o
);
  import sds_pkg::*;

  sample_t mem_q [Capacity];
  sample_t rd_q;

  state_e state_q;
  logic [CountW-1:0] cnt_q;
  logic signed [SumW-1:0] sum_q;
  sample_t min_q, max_q;
  logic ovf_q;

  logic [StepW-1:0] step_q;
  logic [AccW-1:0] rem_q, quo_q, dvd_q;
  logic [CountW-1:0] idx_q;
  logic signed [DiffW-1:0] mean_q;
  logic signed [DiffW-1:0] diff_q;
  logic [2*DiffW-3:0] sq_q;
  logic [AccW-1:0] acc_q;
  logic rd_v_q, diff_v_q, sq_v_q;
  logic [VarW-1:0] var_q;
  logic [VarW-1:0] sqv_q;
  logic [RootW-1:0] root_q;
  logic [RootW+1:0] srem_q;

  logic accept;
  logic store;
  logic issue;
  logic out_load;
  logic [SumW-1:0] mag;
  logic [AccW-1:0] den, trial;
  logic [DiffW-2:0] ad;
  logic [RootW+3:0] s_cur, s_sub;

  assign ready_o  = (state_q == StLoad);
  assign accept   = valid_i && ready_o;
  assign store    = accept && has_sample_i && (cnt_q < CountW'(Capacity));
  assign issue    = (state_q == StPass) && (idx_q < cnt_q);
  assign out_load = (state_q == StOut) && (!valid_o || ready_i);

  always_ff @(posedge clk_i) begin
    if (store) mem_q[cnt_q[AddrW-1:0]] <= sample_i;
    if (issue) rd_q <= mem_q[idx_q[AddrW-1:0]];
  end

  assign mag   = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign den   = (state_q == StMean) ? AccW'({cnt_q, 1'b0}) : AccW'(cnt_q);
  assign trial = {rem_q[AccW-2:0], dvd_q[AccW-1]};
  assign ad    = diff_q[DiffW-1] ? (DiffW-1)'(-diff_q) : (DiffW-1)'(diff_q);
  assign s_cur = {srem_q, sqv_q[VarW-1 -: 2]};
  assign s_sub = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      cnt_q    <= '0;
      sum_q    <= '0;
      min_q    <= SampleMax;
      max_q    <= SampleMin;
      ovf_q    <= 1'b0;
      step_q   <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      dvd_q    <= '0;
      idx_q    <= '0;
      mean_q   <= '0;
      diff_q   <= '0;
      sq_q     <= '0;
      acc_q    <= '0;
      rd_v_q   <= 1'b0;
      diff_v_q <= 1'b0;
      sq_v_q   <= 1'b0;
      var_q    <= '0;
      sqv_q    <= '0;
      root_q   <= '0;
      srem_q   <= '0;
    end else begin
      unique case (state_q)
        StLoad: begin
          if (store) begin
            cnt_q <= cnt_q + 1'b1;
            sum_q <= sum_q + SumW'(sample_i);
            if (sample_i < min_q) min_q <= sample_i;
            if (sample_i > max_q) max_q <= sample_i;
          end else if (accept && has_sample_i) begin
            ovf_q <= 1'b1;
          end
          if (accept && last_i) state_q <= StPrep;
        end
        StPrep: begin
          rem_q   <= '0;
          dvd_q   <= AccW'({mag, 1'b0}) + AccW'(cnt_q);
          step_q  <= '0;
          state_q <= (cnt_q == '0) ? StOut : StMean;
        end
        StMean: begin
          if (trial >= den) begin
            rem_q <= trial - den;
            quo_q <= {quo_q[AccW-2:0], 1'b1};
          end else begin
            rem_q <= trial;
            quo_q <= {quo_q[AccW-2:0], 1'b0};
          end
          dvd_q  <= {dvd_q[AccW-2:0], 1'b0};
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(AccW - 1)) state_q <= StRound;
        end
        StRound: begin
          mean_q  <= sum_q[SumW-1] ? -DiffW'(quo_q) : DiffW'(quo_q);
          idx_q   <= '0;
          acc_q   <= '0;
          state_q <= StPass;
        end
        StPass: begin
          rd_v_q <= issue;
          if (issue) idx_q <= idx_q + 1'b1;
          diff_v_q <= rd_v_q;
          if (rd_v_q) diff_q <= DiffW'(rd_q) - mean_q;
          sq_v_q <= diff_v_q;
          if (diff_v_q) sq_q <= (2*DiffW-2)'(ad) * (2*DiffW-2)'(ad);
          if (sq_v_q) acc_q <= acc_q + AccW'(sq_q);
          if (!issue && !rd_v_q && !diff_v_q && !sq_v_q) begin
            state_q <= StVar;
            rem_q   <= '0;
            dvd_q   <= acc_q;
            step_q  <= '0;
          end
        end
        StVar: begin
          if (trial >= den) begin
            rem_q <= trial - den;
            quo_q <= {quo_q[AccW-2:0], 1'b1};
          end else begin
            rem_q <= trial;
            quo_q <= {quo_q[AccW-2:0], 1'b0};
          end
          dvd_q  <= {dvd_q[AccW-2:0], 1'b0};
          step_q <= (step_q == StepW'(AccW - 1)) ? '0 : step_q + 1'b1;
          if (step_q == StepW'(AccW - 1)) state_q <= StSqrt;
        end
        StSqrt: begin
          if (step_q == '0) begin
            var_q  <= VarW'(quo_q);
            sqv_q  <= VarW'(quo_q);
            root_q <= '0;
            srem_q <= '0;
            step_q <= StepW'(1);
          end else begin
            if (s_cur >= s_sub) begin
              srem_q <= (RootW+2)'(s_cur - s_sub);
              root_q <= {root_q[RootW-2:0], 1'b1};
            end else begin
              srem_q <= s_cur[RootW+1:0];
              root_q <= {root_q[RootW-2:0], 1'b0};
            end
            sqv_q  <= {sqv_q[VarW-3:0], 2'b00};
            step_q <= step_q + 1'b1;
            if (step_q == StepW'(RootW)) state_q <= StOut;
          end
        end
        StOut: begin
          if (out_load) begin
            state_q <= StLoad;
            cnt_q   <= '0;
            sum_q   <= '0;
            min_q   <= SampleMax;
            max_q   <= SampleMin;
            ovf_q   <= 1'b0;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o         <= 1'b0;
      sample_count_o  <= '0;
      mean_value_o    <= '0;
      minimum_o       <= '0;
      maximum_o       <= '0;
      swing_o         <= '0;
      variance_o      <= '0;
      std_deviation_o <= '0;
      status_o        <= StatusOk;
    end else if (out_load) begin
      valid_o        <= 1'b1;
      sample_count_o <= cnt_q;
      if (cnt_q == '0) begin
        mean_value_o    <= '0;
        minimum_o       <= '0;
        maximum_o       <= '0;
        swing_o         <= '0;
        variance_o      <= '0;
        std_deviation_o <= '0;
        status_o        <= StatusEmpty;
      end else begin
        mean_value_o    <= mean_q[SampleW-1:0];
        minimum_o       <= min_q;
        maximum_o       <= max_q;
        swing_o         <= max_q - min_q;
        variance_o      <= var_q;
        std_deviation_o <= root_q;
        status_o        <= ovf_q ? StatusOverflow : StatusOk;
      end
    end else if (ready_i) begin
      valid_o <= 1'b0;
    end
  end
endmodule
